### rtl/bda_pkg.sv
// ---------------------------------------------------------------------------
// Button debounce package
// Shared widths, codes, reset values and state types for the debouncer.
// ---------------------------------------------------------------------------
package bda_pkg;

    localparam int NUM_BUTTONS = 3;
    localparam int BTN_IDX_W   = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam int HOLD_W      = 16;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int REP_W       = 2;

    // Request kinds carried on s_tuser
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_HOLD_TICKS    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_PRESSED_LEVEL = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_REPEAT_BUTTON = 2'd2;

    // Configuration reset values
    localparam logic [HOLD_W-1:0] HOLD_TICKS_RST    = 16'd100;
    localparam logic              PRESSED_LEVEL_RST = 1'b0;
    localparam logic [REP_W-1:0]  REPEAT_BUTTON_RST = 2'd1;

    typedef struct packed {
        logic [HOLD_W-1:0] hold_ticks;
        logic              pressed_level;
        logic [REP_W-1:0]  repeat_button;
    } bda_cfg_t;

    typedef struct packed {
        logic [NUM_BUTTONS-1:0] oldest;
        logic [NUM_BUTTONS-1:0] middle;
        logic [NUM_BUTTONS-1:0] newest;
        logic [NUM_BUTTONS-1:0] accepted;
        logic [NUM_BUTTONS-1:0] flags;
        logic [HOLD_W-1:0]      hold_cnt;
    } bda_state_t;

endpackage

### rtl/bda_step.sv
// ---------------------------------------------------------------------------
// Button debounce next-state logic
// Works out the state and result of one tick or query request.
// ---------------------------------------------------------------------------
module bda_step import bda_pkg::*; (
    input  bda_cfg_t                cfg,
    input  bda_state_t              state,
    input  logic                    opcode,
    input  logic [NUM_BUTTONS-1:0]  pin_levels,
    input  logic [BTN_IDX_W-1:0]    query_index,
    output bda_state_t              state_next,
    output logic                    pressed
);

    logic [NUM_BUTTONS-1:0] stable;
    logic [NUM_BUTTONS-1:0] changed;
    logic [NUM_BUTTONS-1:0] press_lvl;
    logic [NUM_BUTTONS-1:0] newly_pressed;
    logic [NUM_BUTTONS-1:0] rep_bit;
    logic                   rep_valid;
    logic [HOLD_W-1:0]      cnt_dec;
    logic                   query_valid;

    always_comb begin
        state_next = state;
        pressed    = 1'b0;

        // Three-sample history, taken from the incoming pins
        stable        = ~(state.middle ^ state.newest) & ~(state.newest ^ pin_levels);
        changed       = stable & (pin_levels ^ state.accepted);
        press_lvl     = {NUM_BUTTONS{cfg.pressed_level}};
        newly_pressed = changed & ~(pin_levels ^ press_lvl);

        rep_valid = ({{(32-REP_W){1'b0}}, cfg.repeat_button} < NUM_BUTTONS);
        rep_bit   = '0;
        if (rep_valid) begin
            rep_bit[cfg.repeat_button[BTN_IDX_W-1:0]] = 1'b1;
        end
        cnt_dec = state.hold_cnt - 1'b1;

        query_valid = ({{(32-BTN_IDX_W){1'b0}}, query_index} < NUM_BUTTONS);

        unique case (opcode)
            OP_TICK: begin
                state_next.oldest   = state.middle;
                state_next.middle   = state.newest;
                state_next.newest   = pin_levels;
                state_next.accepted = (state.accepted & ~changed) | (pin_levels & changed);
                state_next.flags    = state.flags | newly_pressed;

                // Auto-repeat on the selected button only, once per tick
                if (rep_valid) begin
                    if ((newly_pressed & rep_bit) != '0) begin
                        state_next.hold_cnt = cfg.hold_ticks;
                    end else if (((stable & rep_bit) != '0) && ((changed & rep_bit) == '0)
                                 && (state.hold_cnt != '0)) begin
                        if ((cnt_dec == '0) &&
                            (((pin_levels & rep_bit) != '0) == cfg.pressed_level)) begin
                            state_next.flags    = state.flags | newly_pressed | rep_bit;
                            state_next.hold_cnt = cfg.hold_ticks;
                        end else begin
                            state_next.hold_cnt = cnt_dec;
                        end
                    end
                end
            end
            OP_QUERY: begin
                // A hit on the asked button clears every flag
                if (query_valid && state.flags[query_index]) begin
                    pressed          = 1'b1;
                    state_next.flags = '0;
                end
            end
            default: begin
                state_next = state;
            end
        endcase
    end

endmodule

### rtl/button_debounce_autorepeat.sv
// ---------------------------------------------------------------------------
// Button debouncer with auto-repeat
// Three-sample debounce of NUM_BUTTONS pins, press flags and a held-button
// repeat, driven by tick and query requests on a stream interface.
// ---------------------------------------------------------------------------
// Result: registered, leaving on m_tdata in the cycle after its request is taken.
// Throughput: one request per cycle; while a result is held off the input
// stalls, and the next request is taken in the cycle that result drains.
// Reset (aresetn low, synchronous): sample history, accepted levels, flags
// and hold counter go to zero; configuration returns to its reset values.
// ---------------------------------------------------------------------------
module button_debounce_autorepeat import bda_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,

    // Configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    // Request channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [2:0] pin_levels, [4:3] query_index
    input  logic [0:0]            s_tuser,   // [0] opcode

    // Result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata    // [0] pressed, [3:1] press_flags
);

    bda_cfg_t               cfg_reg;
    bda_state_t             state_reg;
    bda_state_t             state_next;
    logic                   step_pressed;
    logic                   m_tvalid_reg;
    logic [7:0]             m_tdata_reg;
    logic                   s_accept;
    logic [NUM_BUTTONS-1:0] req_pins;
    logic [BTN_IDX_W-1:0]   req_query;

    // The request side is ready whenever the output register is empty or is
    // being emptied in this same cycle.
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    assign req_pins  = s_tdata[NUM_BUTTONS-1:0];
    assign req_query = s_tdata[3 +: BTN_IDX_W];

    // Configuration registers. Writes must arrive only while the block is idle;
    // the block does not enforce this and has no interlock against in-flight requests.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.hold_ticks    <= HOLD_TICKS_RST;
            cfg_reg.pressed_level <= PRESSED_LEVEL_RST;
            cfg_reg.repeat_button <= REPEAT_BUTTON_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_HOLD_TICKS:    cfg_reg.hold_ticks    <= cfg_wdata[HOLD_W-1:0];
                CFG_PRESSED_LEVEL: cfg_reg.pressed_level <= cfg_wdata[0];
                CFG_REPEAT_BUTTON: cfg_reg.repeat_button <= cfg_wdata[REP_W-1:0];
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    // All of the per-request work sits in one combinational pass.
    bda_step u_step (
        .cfg         (cfg_reg),
        .state       (state_reg),
        .opcode      (s_tuser[0]),
        .pin_levels  (req_pins),
        .query_index (req_query),
        .state_next  (state_next),
        .pressed     (step_pressed)
    );

    // Debounce state advances only on an accepted request.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (s_accept) begin
            state_reg <= state_next;
        end
    end

    // Output register: valid is control, the data needs no reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_tdata_reg <= {{(7-NUM_BUTTONS){1'b0}}, state_next.flags, step_pressed};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

### sim/tb.sv
// ---------------------------------------------------------------------------
// Testbench for the button debouncer with auto-repeat
// Drives tick and query requests over the stream interface, predicts every
// result with a cycle-free model of the debounce and repeat logic, and
// compares each result field by field under random idling on both sides.
// ---------------------------------------------------------------------------
module tb;
    import bda_pkg::*;

    // The run is stopped here if the block hangs; this is many times the
    // slowest legal run of some 670 requests.
    localparam int CYCLE_LIMIT = 200000;
    localparam int DIRECTED_ROWS = 25;
    localparam int PHASES = 8;
    localparam int PHASE_REQUESTS = 80;
    localparam int MAX_GAP = 19;

    typedef enum logic {CHK_MODEL, CHK_FIXED} row_check_e;

    // One result: the query answer and the press flags after the request.
    typedef struct packed {
        logic                   pressed;
        logic [NUM_BUTTONS-1:0] flags;
    } report_t;

    typedef struct packed {
        logic                   opcode;
        logic [NUM_BUTTONS-1:0] pins;
        logic [1:0]             query_idx;
        row_check_e             check;
        report_t                fixed_report;
    } stim_row_t;

    typedef struct packed {
        logic [HOLD_W-1:0] hold_ticks;
        logic              pressed_level;
        logic [REP_W-1:0]  repeat_button;
        logic              src_steady;
        logic              snk_steady;
        logic [7:0]        sink_stall;
    } phase_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = '0;   // [2:0] pin_levels, [4:3] query_index
    logic [0:0]            s_tuser = '0;   // [0] opcode
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [7:0]            m_tdata;        // [0] pressed, [3:1] press_flags

    // Predictor copy of the block's state and configuration.
    logic [NUM_BUTTONS-1:0] smp_oldest = '0;
    logic [NUM_BUTTONS-1:0] smp_middle = '0;
    logic [NUM_BUTTONS-1:0] smp_newest = '0;
    logic [NUM_BUTTONS-1:0] acc_levels = '0;
    logic [NUM_BUTTONS-1:0] press_flags = '0;
    logic [HOLD_W-1:0]      hold_count = '0;
    logic [HOLD_W-1:0]      hold_ticks_cfg = HOLD_TICKS_RST;
    logic                   level_cfg = PRESSED_LEVEL_RST;
    logic [REP_W-1:0]       repeat_cfg = REPEAT_BUTTON_RST;

    report_t pending_reports[$];
    int      fault_count = 0;
    int      cycle_count = 0;

    // Idling control shared between the stimulus and the result sink.
    bit src_steady = 1'b0;
    bit snk_steady = 1'b0;
    int sink_hold_cycles = 0;

    // Directed requests under the reset configuration (hold 100, pressed
    // level low, button 1 repeats). Rows with a fixed result are those that
    // follow directly from reset, an out-of-range query or a full press.
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{OP_QUERY, 3'd0, 2'd0, CHK_FIXED, '{1'b0, 3'd0}},  // query straight after reset
        '{OP_QUERY, 3'd0, 2'd3, CHK_FIXED, '{1'b0, 3'd0}},  // query index out of range
        '{OP_TICK,  3'd7, 2'd0, CHK_MODEL, '{1'b0, 3'd0}},
        '{OP_TICK,  3'd7, 2'd0, CHK_MODEL, '{1'b0, 3'd0}},
        '{OP_TICK,  3'd7, 2'd0, CHK_FIXED, '{1'b0, 3'd0}},  // all released, no flag
        '{OP_TICK,  3'd0, 2'd0, CHK_MODEL, '{1'b0, 3'd0}},
        '{OP_TICK,  3'd0, 2'd0, CHK_MODEL, '{1'b0, 3'd0}},
        '{OP_TICK,  3'd0, 2'd0, CHK_FIXED, '{1'b0, 3'd7}},  // all pressed together
        '{OP_QUERY, 3'd7, 2'd3, CHK_FIXED, '{1'b0, 3'd7}},  // out of range keeps flags
        '{OP_QUERY, 3'd0, 2'd2, CHK_FIXED, '{1'b1, 3'd0}},  // hit clears every flag
        '{OP_QUERY, 3'd0, 2'd1, CHK_FIXED, '{1'b0, 3'd0}},
        '{OP_TICK,  3'd2, 2'd0, CHK_MODEL, '{1'b0, 3'd0}},  // bounce on the pins
        '{OP_TICK,  3'd5, 2'd0, CHK_MODEL, '{1'b0, 3'd0}},
        '{OP_TICK,  3'd0, 2'd0, CHK_MODEL, '{1'b0, 3'd0}},
        '{OP_TICK,  3'd0, 2'd0, CHK_MODEL, '{1'b0, 3'd0}},
        '{OP_TICK,  3'd0, 2'd0, CHK_MODEL, '{1'b0, 3'd0}},
        '{OP_TICK,  3'd1, 2'd0, CHK_MODEL, '{1'b0, 3'd0}},
        '{OP_TICK,  3'd1, 2'd0, CHK_MODEL, '{1'b0, 3'd0}},
        '{OP_TICK,  3'd1, 2'd0, CHK_MODEL, '{1'b0, 3'd0}},
        '{OP_TICK,  3'd6, 2'd0, CHK_MODEL, '{1'b0, 3'd0}},
        '{OP_TICK,  3'd6, 2'd0, CHK_MODEL, '{1'b0, 3'd0}},
        '{OP_TICK,  3'd6, 2'd0, CHK_MODEL, '{1'b0, 3'd0}},
        '{OP_TICK,  3'd6, 2'd0, CHK_MODEL, '{1'b0, 3'd0}},
        '{OP_QUERY, 3'd3, 2'd0, CHK_MODEL, '{1'b0, 3'd0}},
        '{OP_QUERY, 3'd4, 2'd1, CHK_MODEL, '{1'b0, 3'd0}}
    };

    // Configuration phases of the random part. They cover both ends of the
    // hold time (zero included, which disables repeats), both pressed
    // levels and every repeat selector, the unused value 3 among them. The
    // sixth phase holds the result side off for a long stretch while the
    // sender keeps offering, so the block fills up and stalls its input.
    phase_t run_phases [PHASES] = '{
        '{16'd3,     1'b0, 2'd1, 1'b0, 1'b0, 8'd0},
        '{16'd1,     1'b1, 2'd0, 1'b1, 1'b0, 8'd0},
        '{16'd65535, 1'b0, 2'd2, 1'b0, 1'b1, 8'd0},
        '{16'd0,     1'b1, 2'd1, 1'b0, 1'b0, 8'd0},
        '{16'd2,     1'b0, 2'd3, 1'b1, 1'b1, 8'd0},
        '{16'd5,     1'b1, 2'd2, 1'b1, 1'b0, 8'd150},
        '{16'd4,     1'b0, 2'd0, 1'b0, 1'b0, 8'd0},
        '{16'd2,     1'b1, 2'd1, 1'b0, 1'b1, 8'd0}
    };

    button_debounce_autorepeat i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #4 aclk = ~aclk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Works out the result of one accepted request and advances the
    // predicted state. A tick shifts the pins into the three-sample history,
    // takes any level that has been steady for three samples, flags new
    // presses and runs the hold countdown of the repeat button, if it names
    // a real button. A query that hits its flag clears all of them.
    function automatic report_t debounce_request(logic opcode,
                                                 logic [NUM_BUTTONS-1:0] pins,
                                                 logic [1:0] query_idx);
        report_t                result;
        logic [NUM_BUTTONS-1:0] stable;
        logic [NUM_BUTTONS-1:0] changed;
        logic [NUM_BUTTONS-1:0] newly_pressed;
        logic [NUM_BUTTONS-1:0] rep_bit;

        result.pressed = 1'b0;
        if (opcode == OP_TICK) begin
            smp_oldest = smp_middle;
            smp_middle = smp_newest;
            smp_newest = pins;
            stable = ~(smp_oldest ^ smp_middle) & ~(smp_middle ^ smp_newest);
            changed = stable & (smp_newest ^ acc_levels);
            acc_levels = (acc_levels & ~changed) | (smp_newest & changed);
            newly_pressed = changed & ~(smp_newest ^ {NUM_BUTTONS{level_cfg}});
            press_flags = press_flags | newly_pressed;
            if (repeat_cfg < NUM_BUTTONS) begin
                rep_bit = NUM_BUTTONS'(1) << repeat_cfg;
                if ((newly_pressed & rep_bit) != '0) begin
                    hold_count = hold_ticks_cfg;
                end else if ((stable & rep_bit) != '0 && (changed & rep_bit) == '0) begin
                    // A release during the countdown still counts down,
                    // but the pressed-level test below then sets no flag.
                    if (hold_count != '0) begin
                        hold_count = hold_count - 1'b1;
                        if (hold_count == '0 && smp_newest[repeat_cfg] == level_cfg) begin
                            press_flags = press_flags | rep_bit;
                            hold_count = hold_ticks_cfg;
                        end
                    end
                end
            end
        end else if (query_idx < NUM_BUTTONS && press_flags[query_idx]) begin
            result.pressed = 1'b1;
            press_flags = '0;
        end
        result.flags = press_flags;
        return result;
    endfunction

    // The predictor copy follows a register write at once, since writes
    // happen only while nothing is in flight.
    task automatic write_register(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_HOLD_TICKS:    hold_ticks_cfg = value[HOLD_W-1:0];
            CFG_PRESSED_LEVEL: level_cfg = value[0];
            CFG_REPEAT_BUTTON: repeat_cfg = value[REP_W-1:0];
            default: ;
        endcase
    endtask

    // Offers one request after a random gap (none while src_steady is set) and
    // returns at the edge that takes it. The valid stays high when the next
    // request follows with no gap, so it is never lowered and raised within one
    // step. Handshake signals are read at the edge, before any of that edge's updates.
    task automatic offer_request(logic opcode, logic [NUM_BUTTONS-1:0] pins,
                                 logic [1:0] query_idx, row_check_e check,
                                 report_t fixed_report);
        int      gap;
        report_t predicted;

        gap = src_steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= opcode;
        s_tdata  <= {3'b000, query_idx, pins};
        do @(posedge aclk); while (!s_tready);
        predicted = debounce_request(opcode, pins, query_idx);
        pending_reports.push_back(check == CHK_FIXED ? fixed_report : predicted);
    endtask

    // Waits until every expected result has been drained and the output
    // register is empty, so that configuration can be changed safely.
    task automatic wait_drained();
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic log_fault(string what);
        if (fault_count < 10) $display("%0t: %s", $realtime, what);
        fault_count++;
    endtask

    // Result side: draws a random stall before each result (none while
    // snk_steady is set), or takes a long hold-off when one is asked for,
    // then compares the result with the oldest expectation.
    initial begin : result_sink
        int      gap;
        report_t want;

        wait (aresetn === 1'b1);
        forever begin
            if (sink_hold_cycles > 0) begin
                gap = sink_hold_cycles;
                sink_hold_cycles = 0;
            end else begin
                gap = snk_steady ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            if (pending_reports.size() == 0) begin
                log_fault($sformatf("result with nothing expected: data %h", m_tdata));
            end else begin
                want = pending_reports.pop_front();
                if (m_tdata[0] !== want.pressed || m_tdata[3:1] !== want.flags) begin
                    log_fault($sformatf("mismatch: pressed %b flags %b, got pressed %b flags %b",
                                        want.pressed, want.flags, m_tdata[0], m_tdata[3:1]));
                end
            end
        end
    end

    // Stimulus: reset, the directed table under the reset configuration,
    // then the random phases. Random ticks mostly hold a pin pattern for a
    // dozen ticks or so, so that levels settle and held buttons repeat; a
    // tenth of them carry a one-tick glitch on some pins as noise.
    initial begin : stimulus
        logic [NUM_BUTTONS-1:0] held_pins;
        logic [NUM_BUTTONS-1:0] pins;
        logic [1:0]             query_idx;
        report_t                no_report;

        no_report = '0;
        held_pins = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            offer_request(directed_rows[r].opcode, directed_rows[r].pins,
                          directed_rows[r].query_idx, directed_rows[r].check,
                          directed_rows[r].fixed_report);
        end
        s_tvalid <= 1'b0;

        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            // Changing the repeat button here leaves the hold counter as it
            // is, so a countdown in progress carries over to the new button.
            write_register(CFG_HOLD_TICKS, CFG_DATA_W'(run_phases[p].hold_ticks));
            write_register(CFG_PRESSED_LEVEL, CFG_DATA_W'(run_phases[p].pressed_level));
            write_register(CFG_REPEAT_BUTTON, CFG_DATA_W'(run_phases[p].repeat_button));
            src_steady = run_phases[p].src_steady;
            snk_steady = run_phases[p].snk_steady;
            sink_hold_cycles = run_phases[p].sink_stall;
            for (int i = 0; i < PHASE_REQUESTS; i++) begin
                if ($urandom_range(0, 9) < 7) begin
                    if ($urandom_range(0, 11) == 0) begin
                        held_pins = NUM_BUTTONS'($urandom_range(0, 7));
                    end
                    pins = held_pins;
                    if ($urandom_range(0, 9) == 0) begin
                        pins = held_pins ^ NUM_BUTTONS'($urandom_range(1, 7));
                    end
                    offer_request(OP_TICK, pins, 2'($urandom_range(0, 3)), CHK_MODEL,
                                  no_report);
                end else begin
                    query_idx = 2'($urandom_range(0, 3));
                    offer_request(OP_QUERY, NUM_BUTTONS'($urandom_range(0, 7)), query_idx,
                                  CHK_MODEL, no_report);
                end
            end
            s_tvalid <= 1'b0;
        end

        wait_drained();
        repeat (4) @(posedge aclk);
        if (fault_count == 0 && pending_reports.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
